### sv/rkt_pkg.sv
// Shared types, codes and helpers for the reference-counted key table.
// Used by rkt_cell and refcounted_key_table_top.
package rkt_pkg;

  localparam int IDX_W   = 6;   // covers up to 64 entries
  localparam int MAX_RES = 16;  // removals per sweep
  localparam int N_W     = 5;

  typedef enum logic [1:0] {
    FN_BIND   = 2'd0,
    FN_UNBIND = 2'd1,
    FN_INSERT = 2'd2,
    FN_SWEEP  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_MISS  = 3'd1,
    ST_DUP   = 3'd2,
    ST_FULL  = 3'd3,
    ST_EMPTY = 3'd4,
    ST_NONE  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CMD_INC   = 2'd0,
    CMD_DEC   = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_kind_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_FINISH = 2'd2
  } state_t;

  // Search token walking down the cell row.
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free;
    logic [IDX_W-1:0] free_idx;
    logic [N_W-1:0]   n;
  } tok_t;

  // Update broadcast to all cells at the end of an operation.
  typedef struct packed {
    logic               en;
    cmd_kind_t          kind;
    logic [IDX_W-1:0]   idx;
    logic [63:0]        key;
    logic [31:0]        handle;
    logic signed [7:0]  count;
  } cmd_t;

  typedef struct packed {
    logic               valid;
    logic [63:0]        key;
    logic [31:0]        handle;
    logic signed [7:0]  count;
  } entry_t;

  function automatic logic signed [7:0] sat_inc(input logic signed [7:0] c);
    return (c == 8'sd127) ? c : c + 8'sd1;
  endfunction

  function automatic logic signed [7:0] sat_dec(input logic signed [7:0] c);
    return (c == -8'sd128) ? c : c - 8'sd1;
  endfunction

endpackage

### sv/rkt_cell.sv
// One table entry with its slice of the search token pipeline.
// Depends on rkt_pkg.
module rkt_cell #(
  parameter int INDEX = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rkt_pkg::tok_t         tok_in,
  output rkt_pkg::tok_t         tok_out,
  input  rkt_pkg::func_t        op_func,
  input  logic [63:0]           op_key,
  input  logic                  stall,
  input  rkt_pkg::cmd_t         cmd,
  output rkt_pkg::entry_t       ent,
  output logic                  want
);

  logic               vld;
  logic [63:0]        ekey;
  logic [31:0]        ehandle;
  logic signed [7:0]  ecount;
  rkt_pkg::tok_t      tok_q;
  rkt_pkg::tok_t      tok_next;
  logic               cmd_hit;

  always_comb begin
    cmd_hit = cmd.en && (cmd.idx == rkt_pkg::IDX_W'(INDEX));
    want = tok_in.valid && (op_func == rkt_pkg::FN_SWEEP) && vld && (ecount <= 8'sd0) &&
           (tok_in.n < rkt_pkg::N_W'(rkt_pkg::MAX_RES));
    tok_next = tok_in;
    if (tok_in.valid) begin
      if ((op_func == rkt_pkg::FN_BIND || op_func == rkt_pkg::FN_INSERT) &&
          vld && ekey == op_key && !tok_in.hit) begin
        tok_next.hit     = 1'b1;
        tok_next.hit_idx = rkt_pkg::IDX_W'(INDEX);
      end
      if (!vld && !tok_in.free) begin
        tok_next.free     = 1'b1;
        tok_next.free_idx = rkt_pkg::IDX_W'(INDEX);
      end
      if (want) begin
        tok_next.n = tok_in.n + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= 1'b0;
      tok_q <= '0;
    end else begin
      if (!stall) tok_q <= tok_next;
      if (want && !stall) begin
        vld <= 1'b0;  // drop swept entry
      end else if (cmd_hit && cmd.kind == rkt_pkg::CMD_WRITE) begin
        vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_hit) begin
      case (cmd.kind)
        rkt_pkg::CMD_INC:   ecount <= rkt_pkg::sat_inc(ecount);
        rkt_pkg::CMD_DEC:   ecount <= rkt_pkg::sat_dec(ecount);
        rkt_pkg::CMD_WRITE: begin
          ekey    <= cmd.key;
          ehandle <= cmd.handle;
          ecount  <= cmd.count;
        end
        default: ;
      endcase
    end
  end

  assign tok_out = tok_q;
  assign ent = '{valid: vld, key: ekey, handle: ehandle, count: ecount};

endmodule

### sv/refcounted_key_table_top.sv
// Reference-counted key table: a row of ENTRIES cells searched by a walking token.
// Bind, insert and sweep send the token through every cell in S_SCAN, then S_FINISH registers
// the result (the token crosses one cell per cycle unless a stall holds it); unbind goes
// straight to S_FINISH. One item at a time: the next transfer is taken as the result leaves;
// a sweep holds its scan while a removed entry waits on the output.
// Reset empties the table. Depends on rkt_pkg and rkt_cell.
module refcounted_key_table_top #(
  parameter int ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic [63:0]        key,
  input  logic [3:0]         slot,
  input  logic [31:0]        handle,
  input  logic signed [7:0]  initial_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic [3:0]         slot_out,
  output logic [63:0]        key_out,
  output logic [31:0]        handle_out,
  output logic signed [7:0]  count_out,
  output logic               last
);

  localparam int IW = rkt_pkg::IDX_W;

  rkt_pkg::state_t    state, state_next;
  rkt_pkg::func_t     op_func;
  logic [63:0]        op_key;
  logic [3:0]         op_slot;
  logic [31:0]        op_handle;
  logic signed [7:0]  op_init;
  logic               start;
  rkt_pkg::tok_t      res;

  rkt_pkg::tok_t      tok [ENTRIES+1];
  rkt_pkg::entry_t    ents [ENTRIES];
  logic [ENTRIES-1:0] wants;
  rkt_pkg::cmd_t      cmd;

  logic               pend_valid;
  rkt_pkg::entry_t    pend;
  logic [IW-1:0]      pend_idx;

  logic               accept, oreg_free, want_any, stall, fin_go, range_ok;
  rkt_pkg::entry_t    want_ent, sel_ent;
  logic [IW-1:0]      want_idx, sel_idx;
  rkt_pkg::status_t   f_status;
  logic [IW-1:0]      f_slot;
  rkt_pkg::entry_t    f_ent;

  assign tok[0] = '{valid: start, default: '0};

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    rkt_cell #(.INDEX(i)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1]),
      .op_func (op_func),
      .op_key  (op_key),
      .stall   (stall),
      .cmd     (cmd),
      .ent     (ents[i]),
      .want    (wants[i])
    );
  end

  always_comb begin
    accept    = in_valid && in_ready;
    oreg_free = !out_valid || out_ready;
    want_any  = |wants;
    stall     = want_any && pend_valid && !oreg_free;
    range_ok  = {3'b000, op_slot} < 7'(ENTRIES);
    sel_idx   = (op_func == rkt_pkg::FN_UNBIND) ? IW'(op_slot) : res.hit_idx;
    want_ent  = '0;
    want_idx  = '0;
    sel_ent   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (wants[i]) begin
        want_ent = ents[i];
        want_idx = IW'(i);
      end
      if (sel_idx == IW'(i)) sel_ent = ents[i];
    end
  end

  // Next state, final result and table update.
  always_comb begin
    state_next = state;
    in_ready   = (state == rkt_pkg::S_IDLE);
    fin_go     = (state == rkt_pkg::S_FINISH) && oreg_free;
    f_status   = rkt_pkg::ST_OK;
    f_slot     = '0;
    f_ent      = '0;
    cmd        = '{en: 1'b0, kind: rkt_pkg::CMD_INC, idx: sel_idx, key: op_key,
                   handle: op_handle, count: op_init};
    case (op_func)
      rkt_pkg::FN_BIND: begin
        if (res.hit) begin
          f_slot       = res.hit_idx;
          f_ent        = sel_ent;
          f_ent.count  = rkt_pkg::sat_inc(sel_ent.count);
          cmd.en       = fin_go;
        end else begin
          f_status = rkt_pkg::ST_MISS;
        end
      end
      rkt_pkg::FN_UNBIND: begin
        f_slot = IW'(op_slot);
        if (range_ok && sel_ent.valid) begin
          f_ent       = sel_ent;
          f_ent.count = rkt_pkg::sat_dec(sel_ent.count);
          cmd.en      = fin_go;
          cmd.kind    = rkt_pkg::CMD_DEC;
        end else begin
          f_status = rkt_pkg::ST_EMPTY;
        end
      end
      rkt_pkg::FN_INSERT: begin
        if (res.hit) begin
          f_status = rkt_pkg::ST_DUP;
          f_slot   = res.hit_idx;
          f_ent    = sel_ent;
        end else if (res.free) begin
          f_slot   = res.free_idx;
          f_ent    = '{valid: 1'b1, key: op_key, handle: op_handle, count: op_init};
          cmd.en   = fin_go;
          cmd.kind = rkt_pkg::CMD_WRITE;
          cmd.idx  = res.free_idx;
        end else begin
          f_status = rkt_pkg::ST_FULL;
        end
      end
      default: begin
        if (pend_valid) begin
          f_slot = pend_idx;
          f_ent  = pend;
        end else begin
          f_status = rkt_pkg::ST_NONE;
        end
      end
    endcase
    case (state)
      rkt_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (rkt_pkg::func_t'(func) == rkt_pkg::FN_UNBIND) ?
                       rkt_pkg::S_FINISH : rkt_pkg::S_SCAN;
        end
      end
      rkt_pkg::S_SCAN: begin
        if (tok[ENTRIES].valid) state_next = rkt_pkg::S_FINISH;
      end
      rkt_pkg::S_FINISH: begin
        if (fin_go) state_next = rkt_pkg::S_IDLE;
      end
      default: state_next = rkt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rkt_pkg::S_IDLE;
      start      <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        start      <= (rkt_pkg::func_t'(func) != rkt_pkg::FN_UNBIND);
        pend_valid <= 1'b0;
      end else if (!stall) begin
        start <= 1'b0;
      end
      if (state == rkt_pkg::S_SCAN && want_any && !stall) begin
        pend_valid <= 1'b1;
      end
      if (state == rkt_pkg::S_SCAN && want_any && !stall && pend_valid) begin
        out_valid <= 1'b1;
      end else if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_func   <= rkt_pkg::func_t'(func);
      op_key    <= key;
      op_slot   <= slot;
      op_handle <= handle;
      op_init   <= initial_count;
      res       <= '0;
    end
    if (state == rkt_pkg::S_SCAN && tok[ENTRIES].valid) res <= tok[ENTRIES];
    if (state == rkt_pkg::S_SCAN && want_any && !stall) begin
      pend     <= want_ent;
      pend_idx <= want_idx;
      // hand the previous removal to the output, not yet last
      if (pend_valid) begin
        status     <= rkt_pkg::ST_OK;
        slot_out   <= pend_idx[3:0];
        key_out    <= pend.key;
        handle_out <= pend.handle;
        count_out  <= pend.count;
        last       <= 1'b0;
      end
    end else if (fin_go) begin
      status     <= f_status;
      slot_out   <= f_slot[3:0];
      key_out    <= f_ent.key;
      handle_out <= f_ent.handle;
      count_out  <= f_ent.count;
      last       <= 1'b1;
    end
  end

endmodule
